@@ hw/rtl/rrasc_pkg.sv @@
// Package for the round-reduced permutation block: state and control types,
// the round-constant table, register indexes and the round function helpers.
// Has no dependencies; every rrasc_* module and the top level use it.
package rrasc_pkg;

  localparam int WORD_W        = 64;
  localparam int NUM_WORDS     = 5;
  localparam int STATE_W       = WORD_W * NUM_WORDS;
  localparam int CFG_W         = 4;
  localparam int TABLE_SIZE    = 12;
  localparam int MAX_ROUNDS_DF = 12;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  // Register index decoded from paddr bit 2.
  localparam logic REG_NUM_ROUNDS  = 1'b0;
  localparam logic REG_FIRST_CONST = 1'b1;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  // Per-stage round control: whether the round runs and which constant it uses.
  typedef struct packed {
    logic             en;
    logic [CFG_W-1:0] cidx;
  } ctrl_t;

  function automatic logic [WORD_W-1:0] round_const(input logic [CFG_W-1:0] idx);
    logic [WORD_W-1:0] c;
    c = '0;
    unique case (idx)
      4'd0:    c = 64'h0f00000000000000;
      4'd1:    c = 64'h8700000000000000;
      4'd2:    c = 64'h4b00000000000000;
      4'd3:    c = 64'hc300000000000000;
      4'd4:    c = 64'h2d00000000000000;
      4'd5:    c = 64'ha500000000000000;
      4'd6:    c = 64'h6900000000000000;
      4'd7:    c = 64'he100000000000000;
      4'd8:    c = 64'h1e00000000000000;
      4'd9:    c = 64'h9600000000000000;
      4'd10:   c = 64'h5a00000000000000;
      4'd11:   c = 64'hd200000000000000;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] diffuse(input logic [WORD_W-1:0] v,
                                                input int a, input int b);
    return v ^ rotl(v, a) ^ rotl(v, b);
  endfunction

endpackage

@@ hw/rtl/round_reduced_ascon_permutation.sv @@
// Pipeline: one round per stage; each stage registers its result with a valid bit.
// Throughput: one item per cycle; a stalled output back-pressures stage by stage,
// so the input still takes items while any stage holds a bubble.
// Reset (synchronous, active low) clears all stage valid bits and sets
// num_rounds to 5 and first_constant to 0; payload registers are not reset.
module round_reduced_ascon_permutation #(
  parameter int MAX_ROUNDS = rrasc_pkg::MAX_ROUNDS_DF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata fields from bit 0: in_x0, in_x1, in_x2, in_x3, in_x4
  input  logic [rrasc_pkg::STATE_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata fields from bit 0: out_x0, out_x1, out_x2, out_x3, out_x4
  output logic [rrasc_pkg::STATE_W-1:0]    out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rrasc_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [rrasc_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [rrasc_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  localparam int CIDX_W = rrasc_pkg::CFG_W + 1;

  logic [rrasc_pkg::CFG_W-1:0] num_rounds_r;
  logic [rrasc_pkg::CFG_W-1:0] first_const_r;
  logic [rrasc_pkg::CFG_W-1:0] n_sat;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rounds_r  <= rrasc_pkg::CFG_W'(5);
      first_const_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        rrasc_pkg::REG_NUM_ROUNDS:  num_rounds_r  <= cfg_pwdata[rrasc_pkg::CFG_W-1:0];
        rrasc_pkg::REG_FIRST_CONST: first_const_r <= cfg_pwdata[rrasc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[2])
      rrasc_pkg::REG_NUM_ROUNDS:  cfg_prdata[rrasc_pkg::CFG_W-1:0] = num_rounds_r;
      rrasc_pkg::REG_FIRST_CONST: cfg_prdata[rrasc_pkg::CFG_W-1:0] = first_const_r;
      default: ;
    endcase
  end

  assign n_sat = (num_rounds_r > rrasc_pkg::CFG_W'(MAX_ROUNDS))
               ? rrasc_pkg::CFG_W'(MAX_ROUNDS) : num_rounds_r;

  logic              valid_w [MAX_ROUNDS+1];
  logic              ready_w [MAX_ROUNDS+1];
  rrasc_pkg::state_t state_w [MAX_ROUNDS+1];

  assign valid_w[0] = in_tvalid;
  assign state_w[0] = rrasc_pkg::state_t'(in_tdata);
  assign in_tready  = ready_w[0];

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_stage
    logic [CIDX_W-1:0] cidx;
    rrasc_pkg::ctrl_t  ctrl;

    // Stages read config directly: the user must keep it stable while items are
    // in flight; the block does not enforce it. Rounds past the table are skipped.
    assign cidx      = {1'b0, first_const_r} + CIDX_W'(k);
    assign ctrl.en   = (rrasc_pkg::CFG_W'(k) < n_sat) &&
                       (cidx < CIDX_W'(rrasc_pkg::TABLE_SIZE));
    assign ctrl.cidx = cidx[rrasc_pkg::CFG_W-1:0];

    rrasc_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_w[k]),
      .up_ready (ready_w[k]),
      .up_state (state_w[k]),
      .ctrl     (ctrl),
      .dn_valid (valid_w[k+1]),
      .dn_ready (ready_w[k+1]),
      .dn_state (state_w[k+1])
    );
  end

  assign ready_w[MAX_ROUNDS] = out_tready;
  assign out_tvalid          = valid_w[MAX_ROUNDS];
  assign out_tdata           = rrasc_pkg::STATE_W'(state_w[MAX_ROUNDS]);

endmodule

@@ hw/rtl/rrasc_round.sv @@
// One permutation round: constant addition, bitsliced S-box, linear layer.
// Pure logic; depends on rrasc_pkg.
module rrasc_round (
  input  rrasc_pkg::state_t x_i,
  input  rrasc_pkg::ctrl_t  ctrl_i,
  output rrasc_pkg::state_t x_o
);

  logic [rrasc_pkg::WORD_W-1:0] a0, a1, a2, a3, a4;
  logic [rrasc_pkg::WORD_W-1:0] s0, s1, s2, s3, s4;
  rrasc_pkg::state_t            rnd;

  always_comb begin
    a0 = x_i[0];
    a1 = x_i[1];
    a2 = x_i[2] ^ rrasc_pkg::round_const(ctrl_i.cidx);
    a3 = x_i[3];
    a4 = x_i[4];

    s0 = (a4 & a1) ^ a3 ^ (a2 & a1) ^ a2 ^ (a1 & a0) ^ a1 ^ a0;
    s1 = a4 ^ (a3 & a2) ^ (a3 & a1) ^ a3 ^ (a2 & a1) ^ a2 ^ a1 ^ a0;
    s2 = ~((a4 & a3) ^ a4 ^ a2 ^ a1);
    s3 = (a4 & a0) ^ a4 ^ (a3 & a0) ^ a3 ^ a2 ^ a1 ^ a0;
    s4 = (a4 & a1) ^ a4 ^ a3 ^ (a1 & a0) ^ a1;

    rnd[0] = rrasc_pkg::diffuse(s0, 19, 28);
    rnd[1] = rrasc_pkg::diffuse(s1, 61, 39);
    rnd[2] = rrasc_pkg::diffuse(s2, 1, 6);
    rnd[3] = rrasc_pkg::diffuse(s3, 10, 17);
    rnd[4] = rrasc_pkg::diffuse(s4, 7, 41);

    // A disabled round passes the state through untouched.
    x_o = ctrl_i.en ? rnd : x_i;
  end

endmodule

@@ hw/rtl/rrasc_stage.sv @@
// One pipeline stage: a round followed by the stage register with its valid bit.
// Depends on rrasc_pkg and rrasc_round.
module rrasc_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  rrasc_pkg::state_t up_state,
  input  rrasc_pkg::ctrl_t  ctrl,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rrasc_pkg::state_t dn_state
);

  logic              valid_r;
  rrasc_pkg::state_t state_r;
  rrasc_pkg::state_t state_nxt;

  rrasc_round u_round (
    .x_i    (up_state),
    .ctrl_i (ctrl),
    .x_o    (state_nxt)
  );

  // The stage takes an item when empty or when its own item moves on.
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state_r <= state_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_state = state_r;

endmodule

@@ hw/rtl/rrasc_checker.sv @@
// Port-level checker for the permutation pipeline, bound to the top level.
// Depends on rrasc_pkg and round_reduced_ascon_permutation.
module rrasc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rrasc_pkg::STATE_W-1:0]    out_tdata,
  input logic                             cfg_pready
);

  // The input only stalls when the whole pipeline is full and the output is blocked.
  a_in_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the output could move");

  // A blocked result stays and holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or vanished");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port inserted a wait state");

endmodule

bind round_reduced_ascon_permutation rrasc_checker u_rrasc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

@@ tb/sv/round_reduced_ascon_permutation_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for round_reduced_ascon_permutation: streams 320-bit states
// under several round settings and compares each result with a local predictor.
// Depends on rrasc_pkg and the round_reduced_ascon_permutation RTL.
module round_reduced_ascon_permutation_test;

  localparam int MAX_ROUNDS = rrasc_pkg::MAX_ROUNDS_DF;
  localparam logic [rrasc_pkg::APB_ADDR_W-1:0] ADDR_NUM_ROUNDS  = 3'd0;
  localparam logic [rrasc_pkg::APB_ADDR_W-1:0] ADDR_FIRST_CONST = 3'd4;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 10;
  localparam int MAX_PRINTED     = 50;

  localparam logic [rrasc_pkg::WORD_W-1:0] ROUND_CONSTS [rrasc_pkg::TABLE_SIZE] = '{
    64'h0f00000000000000, 64'h8700000000000000, 64'h4b00000000000000,
    64'hc300000000000000, 64'h2d00000000000000, 64'ha500000000000000,
    64'h6900000000000000, 64'he100000000000000, 64'h1e00000000000000,
    64'h9600000000000000, 64'h5a00000000000000, 64'hd200000000000000
  };
  localparam int ROT_A [rrasc_pkg::NUM_WORDS] = '{19, 61, 1, 10, 7};
  localparam int ROT_B [rrasc_pkg::NUM_WORDS] = '{28, 39, 6, 17, 41};

  // Round settings per phase: saturation, zero rounds and table overrun included.
  localparam logic [rrasc_pkg::CFG_W-1:0] PHASE_ROUNDS [NUM_PHASES] = '{
    4'd12, 4'd1, 4'd0, 4'd15, 4'd12, 4'd4, 4'd15, 4'd6, 4'd3, 4'd12
  };
  localparam logic [rrasc_pkg::CFG_W-1:0] PHASE_FIRST [NUM_PHASES] = '{
    4'd0, 4'd0, 4'd5, 4'd0, 4'd11, 4'd12, 4'd15, 4'd8, 4'd2, 4'd0
  };

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  rrasc_pkg::state_t                in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  rrasc_pkg::state_t                out_tdata;
  logic                             cfg_psel = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite = 1'b0;
  logic [rrasc_pkg::APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [rrasc_pkg::APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [rrasc_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                             cfg_pready;

  // Local copy of the two registers, changed only while the pipeline is empty.
  logic [rrasc_pkg::CFG_W-1:0] rounds_setting = 4'd5;
  logic [rrasc_pkg::CFG_W-1:0] first_const_setting = 4'd0;

  rrasc_pkg::state_t pending_states[$];
  rrasc_pkg::state_t expected_states[$];
  int     mismatch_count = 0;
  int     results_seen = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     hold_left = 0;
  int     stall_cycle = 0;
  logic [7:0] ready_pattern = 8'hff;

  round_reduced_ascon_permutation #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [rrasc_pkg::WORD_W-1:0] rol64(
      input logic [rrasc_pkg::WORD_W-1:0] v, input int n);
    logic [2*rrasc_pkg::WORD_W-1:0] doubled;
    doubled = {v, v} << n;
    return doubled[2*rrasc_pkg::WORD_W-1:rrasc_pkg::WORD_W];
  endfunction

  function automatic rrasc_pkg::state_t permute_state(
      input rrasc_pkg::state_t s, input logic [rrasc_pkg::CFG_W-1:0] rounds,
      input logic [rrasc_pkg::CFG_W-1:0] first);
    rrasc_pkg::state_t x;
    logic [rrasc_pkg::WORD_W-1:0] a0, a1, a2, a3, a4;
    int n;
    int ci;
    x = s;
    n = (int'(rounds) > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds);
    for (int r = 0; r < n; r++) begin
      ci = int'(first) + r;
      // Rounds that would run past the last table entry do nothing at all.
      if (ci < rrasc_pkg::TABLE_SIZE) begin
        x[2] = x[2] ^ ROUND_CONSTS[ci];
        a0 = x[0]; a1 = x[1]; a2 = x[2]; a3 = x[3]; a4 = x[4];
        x[0] = (a4 & a1) ^ a3 ^ (a2 & a1) ^ a2 ^ (a1 & a0) ^ a1 ^ a0;
        x[1] = a4 ^ (a3 & a2) ^ (a3 & a1) ^ a3 ^ (a2 & a1) ^ a2 ^ a1 ^ a0;
        x[2] = ~((a4 & a3) ^ a4 ^ a2 ^ a1);
        x[3] = (a4 & a0) ^ a4 ^ (a3 & a0) ^ a3 ^ a2 ^ a1 ^ a0;
        x[4] = (a4 & a1) ^ a4 ^ a3 ^ (a1 & a0) ^ a1;
        for (int w = 0; w < rrasc_pkg::NUM_WORDS; w++) begin
          x[w] = x[w] ^ rol64(x[w], ROT_A[w]) ^ rol64(x[w], ROT_B[w]);
        end
      end
    end
    return x;
  endfunction

  function automatic logic [rrasc_pkg::WORD_W-1:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly dense random states, with sparse, nearly full and constant words mixed in.
  function automatic rrasc_pkg::state_t random_state();
    rrasc_pkg::state_t s;
    for (int w = 0; w < rrasc_pkg::NUM_WORDS; w++) begin
      case ($urandom_range(0, 7))
        0: s[w] = random_word() & random_word() & random_word();
        1: s[w] = random_word() | random_word() | random_word();
        2: s[w] = ($urandom_range(0, 1) == 0) ? '0 : '1;
        default: s[w] = random_word();
      endcase
    end
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic write_register(input logic [rrasc_pkg::APB_ADDR_W-1:0] addr,
                                input logic [rrasc_pkg::CFG_W-1:0] value);
    logic [rrasc_pkg::APB_DATA_W-1:0] data;
    data = $urandom();
    data[rrasc_pkg::CFG_W-1:0] = value;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr[2] == rrasc_pkg::REG_NUM_ROUNDS) rounds_setting = value;
    else first_const_setting = value;
  endtask

  task automatic wait_until_drained();
    while (pending_states.size() != 0 || in_tvalid || expected_states.size() != 0)
      @(posedge clk);
    repeat (MAX_ROUNDS + 4) @(posedge clk);
  endtask

  // Sender: items go out in bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_states.push_back(permute_state(in_tdata, rounds_setting,
                                                first_const_setting));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_states.size() == 0) begin
          in_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_tdata  <= pending_states.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: checks results and stalls on a byte-wide ready pattern drawn at random.
  always @(posedge clk) begin : receiver
    rrasc_pkg::state_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_states.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_states.pop_front();
          for (int w = 0; w < rrasc_pkg::NUM_WORDS; w++) begin
            if (out_tdata[w] !== want[w]) begin
              report_mismatch($sformatf("result %0d out_x%0d got %h expected %h",
                                        results_seen, w, out_tdata[w], want[w]));
            end
          end
        end
        results_seen++;
        // A long hold-off lets the pipeline fill and push back on the sender.
        if (results_seen == 300 || results_seen == 1100 || results_seen == 1700) begin
          hold_left = 150;
        end
      end
      if (stall_cycle % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = 8'hff;
          1: ready_pattern = 8'($urandom_range(0, 255));
          2: ready_pattern = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
          default: ready_pattern = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
        endcase
      end
      stall_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ready_pattern[stall_cycle[2:0]];
      end
    end
  end

  initial begin : stimulus
    rrasc_pkg::state_t s;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed states under the reset settings: extremes and walking patterns.
    pending_states.push_back('0);
    pending_states.push_back('1);
    pending_states.push_back({rrasc_pkg::NUM_WORDS{64'h5555555555555555}});
    pending_states.push_back({rrasc_pkg::NUM_WORDS{64'haaaaaaaaaaaaaaaa}});
    for (int w = 0; w < rrasc_pkg::NUM_WORDS; w++) begin
      s = '0;
      s[w] = '1;
      pending_states.push_back(s);
      s = '0;
      s[w] = 64'h1 << (w * 13 + 5);
      pending_states.push_back(s);
    end
    s = '0;
    s[4][rrasc_pkg::WORD_W-1] = 1'b1;
    pending_states.push_back(s);
    wait_until_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(ADDR_NUM_ROUNDS, PHASE_ROUNDS[p]);
      write_register(ADDR_FIRST_CONST, PHASE_FIRST[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_states.push_back(random_state());
      wait_until_drained();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
